@@ rtl/assert_macros.svh @@
// Assertion macros for the encoder RTL, included by the back end.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside of reset.
`define RHSE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define RHSE_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ rtl/rhse_pkg.sv @@
// Shared types and constants of the run-length plus Huffman stream encoder.
package rhse_pkg;

    // Code length limit and run limit
    localparam int MAX_CODE_LEN = 16;
    localparam int MAX_RUN      = 255;
    localparam int LEN_LIMIT    = (MAX_CODE_LEN < 16) ? MAX_CODE_LEN : 16;

    localparam logic [7:0] ESC_BYTE    = 8'h90;
    localparam logic [8:0] END_SYMBOL  = 9'd256;
    localparam int         TABLE_DEPTH = 257;

    // Queue depths
    localparam int CQ_DEPTH = 4;
    localparam int RQ_DEPTH = 4;

    // Input opcodes
    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_DATA = 2'd1;
    localparam logic [1:0] OP_END  = 2'd2;

    // Kind of a queued command
    typedef enum logic [1:0] {
        K_LOAD,
        K_DATA,
        K_END
    } t_kind;

    // Command passed from front to back: up to three symbols per item
    typedef struct packed {
        t_kind           kind;
        logic [1:0]      nsym;
        logic [2:0][8:0] sym;
        logic [15:0]     code;
        logic [4:0]      len;
        logic [15:0]     sum;
    } t_cmd;

    // One code table entry
    typedef struct packed {
        logic [4:0]  len;
        logic [15:0] code;
    } t_entry;

    // One result item
    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic        end_of_stream;
        logic [15:0] byte_sum;
    } t_res;

    // Back end sequencer states
    typedef enum logic [1:0] {
        BS_IDLE,
        BS_LOOK,
        BS_EMIT,
        BS_FINAL
    } t_bstate;

endpackage

@@ rtl/rhse_front.sv @@
// Front end: run-length coding, byte sum and the command queue to the back end.
module rhse_front import rhse_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_opcode,
    input  logic [7:0]  i_data_byte,
    input  logic [8:0]  i_load_symbol,
    input  logic [15:0] i_load_code,
    input  logic [4:0]  i_load_length,
    output t_cmd        o_cmd,
    output logic        o_cmd_empty,
    input  logic        i_cmd_pop
);

    localparam int PW = $clog2(CQ_DEPTH);
    localparam int CW = $clog2(CQ_DEPTH + 1);

    logic [7:0]    r_run_byte, n_run_byte;
    logic [7:0]    r_run_count, n_run_count;
    logic          r_hist, n_hist;
    logic [15:0]   r_sum, n_sum;

    t_cmd          r_q [CQ_DEPTH];
    logic [PW-1:0] r_wptr, r_rptr;
    logic [CW-1:0] r_count;

    logic          accept;
    logic          enq;
    t_cmd          ent;
    logic [1:0]    cl_n;
    logic [8:0]    cl_s0, cl_s1;
    logic [8:0]    last_sym;
    logic [15:0]   sum_add;
    logic          do_pop;

    assign full        = (r_count == CW'(CQ_DEPTH));
    assign accept      = push && !full;
    assign o_cmd_empty = (r_count == '0);
    assign o_cmd       = r_q[r_rptr];
    assign do_pop      = i_cmd_pop && !o_cmd_empty;
    assign sum_add     = r_sum + 16'(i_data_byte);

    // Symbols that close the pending run
    always_comb begin
        cl_n  = 2'd0;
        cl_s0 = '0;
        cl_s1 = '0;
        if (r_hist) begin
            if (r_run_byte == ESC_BYTE) begin
                cl_n  = 2'd1;
                cl_s0 = 9'd0;
            end else if (r_run_count == 8'd2) begin
                cl_n  = 2'd1;
                cl_s0 = {1'b0, r_run_byte};
            end else if (r_run_count >= 8'd3) begin
                cl_n  = 2'd2;
                cl_s0 = {1'b0, ESC_BYTE};
                cl_s1 = {1'b0, r_run_count};
            end
        end
    end

    // Classify the accepted item
    always_comb begin
        n_run_byte  = r_run_byte;
        n_run_count = r_run_count;
        n_hist      = r_hist;
        n_sum       = r_sum;
        enq         = 1'b0;
        ent         = '0;
        last_sym    = (i_opcode == OP_END) ? END_SYMBOL : {1'b0, i_data_byte};

        // pending symbols followed by the new one
        ent.nsym = cl_n + 2'd1;
        case (cl_n)
            2'd0: ent.sym[0] = last_sym;
            2'd1: begin
                ent.sym[0] = cl_s0;
                ent.sym[1] = last_sym;
            end
            default: begin
                ent.sym[0] = cl_s0;
                ent.sym[1] = cl_s1;
                ent.sym[2] = last_sym;
            end
        endcase

        if (accept) begin
            case (i_opcode)
                OP_LOAD: begin
                    if (i_load_symbol <= END_SYMBOL) begin
                        enq        = 1'b1;
                        ent.kind   = K_LOAD;
                        ent.nsym   = 2'd0;
                        ent.sym    = '0;
                        ent.sym[0] = i_load_symbol;
                        ent.code   = i_load_code;
                        ent.len    = (i_load_length > 5'(LEN_LIMIT)) ? 5'(LEN_LIMIT)
                                                                    : i_load_length;
                    end
                end
                OP_DATA: begin
                    n_sum = sum_add;
                    if (r_hist && r_run_byte != ESC_BYTE && i_data_byte == r_run_byte &&
                        r_run_count < 8'(MAX_RUN)) begin
                        n_run_count = r_run_count + 8'd1;
                    end else begin
                        enq         = 1'b1;
                        ent.kind    = K_DATA;
                        ent.sum     = sum_add;
                        n_hist      = 1'b1;
                        n_run_byte  = i_data_byte;
                        n_run_count = 8'd1;
                    end
                end
                OP_END: begin
                    enq         = 1'b1;
                    ent.kind    = K_END;
                    ent.sum     = r_sum;
                    n_hist      = 1'b0;
                    n_run_byte  = '0;
                    n_run_count = '0;
                    n_sum       = '0;
                end
                default: ;
            endcase
        end
    end

    // Run state and sum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_byte  <= '0;
            r_run_count <= '0;
            r_hist      <= 1'b0;
            r_sum       <= '0;
        end else begin
            r_run_byte  <= n_run_byte;
            r_run_count <= n_run_count;
            r_hist      <= n_hist;
            r_sum       <= n_sum;
        end
    end

    // Command queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (enq)    r_wptr <= r_wptr + PW'(1);
            if (do_pop) r_rptr <= r_rptr + PW'(1);
            r_count <= r_count + CW'(enq) - CW'(do_pop);
        end
    end

    // Command queue storage
    always_ff @(posedge i_clk) begin
        if (enq) r_q[r_wptr] <= ent;
    end

endmodule

@@ rtl/rhse_back.sv @@
// Back end: code table, symbol lookup and LSB-first bit packing into bytes.
`include "assert_macros.svh"
module rhse_back import rhse_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cmd i_cmd,
    input  logic i_cmd_empty,
    output logic o_cmd_pop,
    output logic o_res_push,
    output t_res o_res,
    input  logic i_res_full
);

    localparam int AW = $clog2(TABLE_DEPTH);

    t_entry       r_tab [TABLE_DEPTH];
    t_entry       r_rd;

    t_bstate      r_state, n_state;
    t_cmd         r_cur, n_cur;
    logic [1:0]   r_idx, n_idx;
    logic [6:0]   r_buf, n_buf;
    logic [2:0]   r_cnt, n_cnt;
    logic [22:0]  r_acc, n_acc;
    logic [4:0]   r_tot, n_tot;

    logic         wr_en, rd_en;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    t_entry       wr_data;

    logic [16:0]  look_mask;
    logic [15:0]  look_bits;
    logic [22:0]  look_acc;
    logic [4:0]   look_tot;

    logic         fin;
    logic [6:0]   fin_buf;
    logic [2:0]   fin_cnt;
    logic         res_push;
    t_res         res_data;

    assign wr_addr    = AW'(i_cmd.sym[0]);
    assign wr_data    = '{len: i_cmd.len, code: i_cmd.code};
    assign o_res_push = res_push;
    assign o_res      = res_data;

    // Merge the looked-up code above the bits already held
    assign look_mask = (17'd1 << r_rd.len) - 17'd1;
    assign look_bits = r_rd.code & look_mask[15:0];
    assign look_acc  = 23'(r_buf) | (23'(look_bits) << r_cnt);
    assign look_tot  = 5'(r_cnt) + r_rd.len;

    // Sequencer
    always_comb begin
        n_state  = r_state;
        n_cur    = r_cur;
        n_idx    = r_idx;
        n_buf    = r_buf;
        n_cnt    = r_cnt;
        n_acc    = r_acc;
        n_tot    = r_tot;
        o_cmd_pop = 1'b0;
        wr_en    = 1'b0;
        rd_en    = 1'b0;
        rd_addr  = '0;
        res_push = 1'b0;
        res_data = '0;
        fin      = 1'b0;
        fin_buf  = '0;
        fin_cnt  = '0;

        case (r_state)
            BS_IDLE: begin
                if (!i_cmd_empty) begin
                    o_cmd_pop = 1'b1;
                    n_cur     = i_cmd;
                    n_idx     = 2'd0;
                    case (i_cmd.kind)
                        K_LOAD: wr_en = 1'b1;
                        K_DATA, K_END: begin
                            if (i_cmd.nsym != 2'd0) begin
                                rd_en   = 1'b1;
                                rd_addr = AW'(i_cmd.sym[0]);
                                n_state = BS_LOOK;
                            end else if (i_cmd.kind == K_END) begin
                                n_state = BS_FINAL;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            BS_LOOK: begin
                if (look_tot >= 5'd8) begin
                    n_state = BS_EMIT;
                    if (!i_res_full) begin
                        res_push = 1'b1;
                        res_data = '{out_byte: look_acc[7:0], byte_valid: 1'b1,
                                     end_of_stream: 1'b0, byte_sum: r_cur.sum};
                        n_acc    = look_acc >> 8;
                        n_tot    = look_tot - 5'd8;
                    end else begin
                        n_acc = look_acc;
                        n_tot = look_tot;
                    end
                end else begin
                    fin     = 1'b1;
                    fin_buf = look_acc[6:0];
                    fin_cnt = look_tot[2:0];
                end
            end
            BS_EMIT: begin
                if (r_tot >= 5'd8) begin
                    if (!i_res_full) begin
                        res_push = 1'b1;
                        res_data = '{out_byte: r_acc[7:0], byte_valid: 1'b1,
                                     end_of_stream: 1'b0, byte_sum: r_cur.sum};
                        n_acc    = r_acc >> 8;
                        n_tot    = r_tot - 5'd8;
                    end
                end else begin
                    fin     = 1'b1;
                    fin_buf = r_acc[6:0];
                    fin_cnt = r_tot[2:0];
                end
            end
            BS_FINAL: begin
                if (!i_res_full) begin
                    res_push = 1'b1;
                    res_data = '{out_byte: (r_cnt != 3'd0) ? {1'b0, r_buf} : 8'd0,
                                 byte_valid: (r_cnt != 3'd0), end_of_stream: 1'b1,
                                 byte_sum: r_cur.sum};
                    n_buf    = '0;
                    n_cnt    = '0;
                    n_state  = BS_IDLE;
                end
            end
            default: n_state = BS_IDLE;
        endcase

        // Symbol done: keep leftover bits, move to the next symbol or finish the command
        if (fin) begin
            n_buf = fin_buf;
            n_cnt = fin_cnt;
            if (2'(r_idx + 2'd1) < r_cur.nsym) begin
                n_idx   = r_idx + 2'd1;
                rd_en   = 1'b1;
                rd_addr = (r_idx == 2'd0) ? AW'(r_cur.sym[1]) : AW'(r_cur.sym[2]);
                n_state = BS_LOOK;
            end else if (r_cur.kind == K_END) begin
                n_state = BS_FINAL;
            end else begin
                n_state = BS_IDLE;
            end
        end
    end

    // Control and bit buffer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BS_IDLE;
            r_idx   <= '0;
            r_buf   <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_buf   <= n_buf;
            r_cnt   <= n_cnt;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cur <= n_cur;
        r_acc <= n_acc;
        r_tot <= n_tot;
    end

    // Code table, registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) r_tab[wr_addr] <= wr_data;
        if (rd_en) r_rd <= r_tab[rd_addr];
    end

    `RHSE_ASSERT(a_push_busy, res_push |-> (r_state != BS_IDLE), "result pushed while idle")
    `RHSE_ASSERT(a_look_read, (r_state == BS_LOOK) |-> $past(rd_en), "lookup without a read")
    `RHSE_ASSERT(a_final_clear, (r_state == BS_FINAL && res_push) |=> (r_state == BS_IDLE && r_cnt == 3'd0), "bit buffer not cleared after end")

endmodule

@@ rtl/rhse_outq.sv @@
// Result queue between the back end and the result ports.
module rhse_outq import rhse_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_res        i_res,
    output logic        o_full,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_out_byte,
    output logic        o_byte_valid,
    output logic        o_end_of_stream,
    output logic [15:0] o_byte_sum
);

    localparam int PW = $clog2(RQ_DEPTH);
    localparam int CW = $clog2(RQ_DEPTH + 1);

    t_res          r_q [RQ_DEPTH];
    logic [PW-1:0] r_wptr, r_rptr;
    logic [CW-1:0] r_count;
    logic          do_push, do_pop;
    t_res          head;

    assign o_full  = (r_count == CW'(RQ_DEPTH));
    assign empty   = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = pop && !empty;
    assign head    = r_q[r_rptr];

    assign o_out_byte      = head.out_byte;
    assign o_byte_valid    = head.byte_valid;
    assign o_end_of_stream = head.end_of_stream;
    assign o_byte_sum      = head.byte_sum;

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) r_wptr <= r_wptr + PW'(1);
            if (do_pop)  r_rptr <= r_rptr + PW'(1);
            r_count <= r_count + CW'(do_push) - CW'(do_pop);
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) r_q[r_wptr] <= i_res;
    end

endmodule

@@ rtl/rle_huffman_stream_encoder_unit.sv @@
// Run-length plus Huffman stream encoder, top level.
//
// Input channel (push/full): one item per request; opcode 0 loads a code
// table entry, 1 carries a data byte, 2 ends the stream. Table entries must
// be loaded before any symbol that uses them is coded.
// Result channel (empty/pop): packed bytes, LSB first, each with the running
// byte sum; the last result of an end request carries end_of_stream.
// A literal whose code completes a byte passes through the command queue,
// the registered table read and the result queue on its way to the result
// ports. The front takes one request per cycle while its 4-entry command
// queue has room; a byte that extends a run costs the back end nothing. The
// back end handles one command at a time: it starts the command, looks up
// each symbol in the table, emits each output byte and finishes each symbol,
// and only back in idle does it pop the next command; it has a single table
// read port and a single byte packer.
// Reset: run state, bit buffer, sum and both queues are cleared; the code
// table holds nothing defined until loaded and is kept across streams.
// Stall: when pop stays low the 4-entry result queue fills, the back end
// halts, the command queue fills and full rises; nothing is lost.
module rle_huffman_stream_encoder_unit import rhse_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_opcode,
    input  logic [7:0]  i_data_byte,
    input  logic [8:0]  i_load_symbol,
    input  logic [15:0] i_load_code,
    input  logic [4:0]  i_load_length,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_out_byte,
    output logic        o_byte_valid,
    output logic        o_end_of_stream,
    output logic [15:0] o_byte_sum
);

    t_cmd cmd;
    logic cmd_empty, cmd_pop;
    logic res_push, res_full;
    t_res res;

    // Run-length coding and command queue
    rhse_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_opcode      (i_opcode),
        .i_data_byte   (i_data_byte),
        .i_load_symbol (i_load_symbol),
        .i_load_code   (i_load_code),
        .i_load_length (i_load_length),
        .o_cmd         (cmd),
        .o_cmd_empty   (cmd_empty),
        .i_cmd_pop     (cmd_pop)
    );

    // Table lookup and bit packing
    rhse_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .o_res_push  (res_push),
        .o_res       (res),
        .i_res_full  (res_full)
    );

    // Result queue
    rhse_outq u_outq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (res_push),
        .i_res           (res),
        .o_full          (res_full),
        .empty           (empty),
        .pop             (pop),
        .o_out_byte      (o_out_byte),
        .o_byte_valid    (o_byte_valid),
        .o_end_of_stream (o_end_of_stream),
        .o_byte_sum      (o_byte_sum)
    );

endmodule

@@ sim/tb.sv @@
// Self-checking testbench for the run-length plus Huffman stream encoder.
module tb;
    import rhse_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Opcode that the encoder ignores
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Expected encoder output: mirrors run coding, table lookup and bit packing
    class rle_huffman_scoreboard;
        logic [15:0] code_mem [TABLE_DEPTH];
        logic [4:0]  len_mem  [TABLE_DEPTH];
        logic [7:0]  run_val;
        logic [7:0]  run_len;
        bit          in_run;
        logic [6:0]  bit_buf;
        int unsigned bit_cnt;
        logic [15:0] running_sum;
        t_res        owed_bytes[$];
        int          errors;

        function new();
            run_val     = '0;
            run_len     = '0;
            in_run      = 1'b0;
            bit_buf     = '0;
            bit_cnt     = 0;
            running_sum = '0;
            errors      = 0;
        endfunction

        function void queue_byte(logic [7:0] b, logic valid, logic eos);
            t_res r;
            r.out_byte      = b;
            r.byte_valid    = valid;
            r.end_of_stream = eos;
            r.byte_sum      = running_sum;
            owed_bytes.push_back(r);
        endfunction

        // Append one symbol's code bits, LSB first, flushing whole bytes
        function void pack_symbol(logic [8:0] sym);
            int unsigned n;
            int unsigned total;
            logic [31:0] mask;
            logic [31:0] acc;
            n = len_mem[sym];
            if (n > LEN_LIMIT) n = LEN_LIMIT;
            mask  = (32'd1 << n) - 32'd1;
            acc   = 32'(bit_buf) | ((32'(code_mem[sym]) & mask) << bit_cnt);
            total = bit_cnt + n;
            while (total >= 8) begin
                queue_byte(acc[7:0], 1'b1, 1'b0);
                acc   = acc >> 8;
                total = total - 8;
            end
            bit_buf = acc[6:0];
            bit_cnt = total;
        endfunction

        // Finish the run in progress (or the zero owed after an escape byte)
        function void close_run();
            if (in_run) begin
                if (run_val == ESC_BYTE) begin
                    pack_symbol(9'd0);
                end else if (run_len == 8'd2) begin
                    pack_symbol({1'b0, run_val});
                end else if (run_len >= 8'd3) begin
                    pack_symbol({1'b0, ESC_BYTE});
                    pack_symbol({1'b0, run_len});
                end
            end
            in_run  = 1'b0;
            run_len = '0;
        endfunction

        // Work out the bytes caused by one accepted request
        function void encode_request(logic [1:0] op, logic [7:0] b, logic [8:0] sym,
                                     logic [15:0] code, logic [4:0] len);
            case (op)
                OP_LOAD: begin
                    if (sym < TABLE_DEPTH) begin
                        code_mem[sym] = code;
                        len_mem[sym]  = (len > LEN_LIMIT) ? 5'(LEN_LIMIT) : len;
                    end
                end
                OP_DATA: begin
                    running_sum = running_sum + 16'(b);
                    if (in_run && run_val != ESC_BYTE && b == run_val && run_len < MAX_RUN) begin
                        run_len = run_len + 8'd1;
                    end else begin
                        close_run();
                        pack_symbol({1'b0, b});
                        in_run  = 1'b1;
                        run_val = b;
                        run_len = 8'd1;
                    end
                end
                OP_END: begin
                    close_run();
                    pack_symbol(END_SYMBOL);
                    if (bit_cnt > 0) queue_byte({1'b0, bit_buf}, 1'b1, 1'b1);
                    else queue_byte(8'h00, 1'b0, 1'b1);
                    run_val     = '0;
                    run_len     = '0;
                    in_run      = 1'b0;
                    bit_buf     = '0;
                    bit_cnt     = 0;
                    running_sum = '0;
                end
                default: ;
            endcase
        endfunction

        // Compare one popped result against the oldest owed byte
        function void check_result(t_res got);
            t_res want;
            if (owed_bytes.size() == 0) begin
                errors++;
                $display("%0t: unexpected result byte=%02h valid=%0b eos=%0b sum=%04h",
                         $realtime, got.out_byte, got.byte_valid, got.end_of_stream,
                         got.byte_sum);
                return;
            end
            want = owed_bytes.pop_front();
            if (got.out_byte !== want.out_byte) begin
                errors++;
                $display("%0t: out_byte expected %02h actual %02h",
                         $realtime, want.out_byte, got.out_byte);
            end
            if (got.byte_valid !== want.byte_valid) begin
                errors++;
                $display("%0t: byte_valid expected %0b actual %0b",
                         $realtime, want.byte_valid, got.byte_valid);
            end
            if (got.end_of_stream !== want.end_of_stream) begin
                errors++;
                $display("%0t: end_of_stream expected %0b actual %0b",
                         $realtime, want.end_of_stream, got.end_of_stream);
            end
            if (got.byte_sum !== want.byte_sum) begin
                errors++;
                $display("%0t: byte_sum expected %04h actual %04h",
                         $realtime, want.byte_sum, got.byte_sum);
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [1:0]  i_opcode = OP_LOAD;
    logic [7:0]  i_data_byte = '0;
    logic [8:0]  i_load_symbol = '0;
    logic [15:0] i_load_code = '0;
    logic [4:0]  i_load_length = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [7:0]  o_out_byte;
    logic        o_byte_valid;
    logic        o_end_of_stream;
    logic [15:0] o_byte_sum;

    rle_huffman_stream_encoder_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_opcode        (i_opcode),
        .i_data_byte     (i_data_byte),
        .i_load_symbol   (i_load_symbol),
        .i_load_code     (i_load_code),
        .i_load_length   (i_load_length),
        .empty           (empty),
        .pop             (pop),
        .o_out_byte      (o_out_byte),
        .o_byte_valid    (o_byte_valid),
        .o_end_of_stream (o_end_of_stream),
        .o_byte_sum      (o_byte_sum)
    );

    rle_huffman_scoreboard sb = new();
    int push_idle_pct = 0;
    int pop_stall_pct = 0;
    int counted_items = 0;

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Result side: random pop stalls
    always @(negedge i_clk) begin
        pop <= ($urandom_range(99) >= pop_stall_pct);
    end

    // Result monitor
    always @(posedge i_clk) begin
        t_res got;
        if (i_rst_n && pop && !empty) begin
            got.out_byte      = o_out_byte;
            got.byte_valid    = o_byte_valid;
            got.end_of_stream = o_end_of_stream;
            got.byte_sum      = o_byte_sum;
            sb.check_result(got);
        end
    end

    // Drive one request; entered and left at a falling edge
    task automatic send_item(logic [1:0] op, logic [7:0] b, logic [8:0] sym,
                             logic [15:0] code, logic [4:0] len);
        while ($urandom_range(99) < push_idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push          <= 1'b1;
        i_opcode      <= op;
        i_data_byte   <= b;
        i_load_symbol <= sym;
        i_load_code   <= code;
        i_load_length <= len;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        sb.encode_request(op, b, sym, code, len);
        @(negedge i_clk);
    endtask

    task automatic load_entry(logic [8:0] sym, logic [15:0] code, logic [4:0] len);
        send_item(OP_LOAD, 8'($urandom), sym, code, len);
    endtask

    // Load one entry with a random code of 0 to 16 bits
    task automatic load_used(logic [8:0] sym);
        load_entry(sym, 16'($urandom), ($urandom_range(99) < 5) ? 5'd0 :
                   5'($urandom_range(1, 16)));
    endtask

    task automatic send_byte(logic [7:0] b);
        send_item(OP_DATA, b, 9'($urandom), 16'($urandom), 5'($urandom));
    endtask

    task automatic send_end();
        send_item(OP_END, 8'($urandom), 9'($urandom), 16'($urandom), 5'($urandom));
    endtask

    // Hold the sender off until every owed byte has been popped
    task automatic drain_results();
        push <= 1'b0;
        @(negedge i_clk);
        while (sb.owed_bytes.size() != 0) @(negedge i_clk);
    endtask

    // Idling mixes: none, sender idle, receiver stall, both
    task automatic set_idling(int mix);
        case (mix)
            1:       begin push_idle_pct = 52; pop_stall_pct = 0;  end
            2:       begin push_idle_pct = 0;  pop_stall_pct = 52; end
            3:       begin push_idle_pct = 13; pop_stall_pct = 13; end
            default: begin push_idle_pct = 0;  pop_stall_pct = 0;  end
        endcase
    endtask

    // Random byte: one of five fixed values in 45% of picks, else a value from 0 to 40
    function automatic logic [7:0] pick_byte();
        int p;
        p = $urandom_range(99);
        if (p < 12) return ESC_BYTE;
        if (p < 45) begin
            case ($urandom_range(3))
                0:       return 8'h00;
                1:       return 8'hFF;
                2:       return 8'h5A;
                default: return 8'hA5;
            endcase
        end
        return 8'($urandom_range(40));
    endfunction

    function automatic logic [4:0] pick_length();
        int p;
        p = $urandom_range(99);
        if (p < 5)  return 5'd0;
        if (p < 15) return 5'($urandom_range(17, 31));
        return 5'($urandom_range(1, 16));
    endfunction

    // Main stimulus
    initial begin
        int slice;
        int run_n;
        int p;
        bit long_run_done;
        logic [7:0] b;
        logic [7:0] prev_b;
        logic [8:0] sym;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Fill the table entries for bytes and run counts up to 40, the fixed
        // byte values and the end symbol
        set_idling(0);
        for (int s = 0; s <= 40; s++) begin
            load_used(9'(s));
        end
        load_used(9'h033);
        load_used(9'h041);
        load_used(9'h055);
        load_used(9'h05A);
        load_used(9'h077);
        load_used({1'b0, ESC_BYTE});
        load_used(9'h0A5);
        load_used(9'h0FF);
        load_used(END_SYMBOL);

        // Directed corner cases
        set_idling(3);
        load_entry(9'd511, 16'hFFFF, 5'd31);          // symbol out of range: ignored
        load_entry(9'd257, 16'h0000, 5'd0);           // symbol out of range: ignored
        send_item(OP_UNUSED, 8'hFF, 9'h1FF, 16'hFFFF, 5'h1F);
        load_entry(END_SYMBOL, 16'hA5C3, 5'd8);       // end code fills one byte exactly
        send_end();                                   // empty end marker
        load_entry(END_SYMBOL, 16'hFFFF, 5'd31);      // over-long length saturates
        load_entry(9'd255, 16'h8001, 5'd17);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_end();
        send_end();                                   // end of an empty stream
        send_byte(ESC_BYTE);
        send_byte(ESC_BYTE);                          // escapes are never run-coded
        send_byte(8'h41);
        send_byte(ESC_BYTE);
        send_end();                                   // zero after escape goes out on end
        send_byte(8'h55);
        send_byte(8'h55);                             // run of two: literal twice
        send_end();
        repeat (4) send_byte(8'h33);                  // run of four: byte, escape, count
        send_end();
        drain_results();

        // Random streams with runs, reloads and noise
        slice = -1;
        long_run_done = 1'b0;
        prev_b = ESC_BYTE;
        while (counted_items < 340) begin
            if (counted_items / 25 != slice) begin
                slice = counted_items / 25;
                drain_results();
                set_idling(slice % 4);
            end
            p = $urandom_range(99);
            if (p < 5) begin
                sym = ($urandom_range(99) < 80) ? 9'($urandom_range(256)) :
                      9'($urandom_range(257, 511));
                load_entry(sym, 16'($urandom), pick_length());
                if (sym < TABLE_DEPTH) counted_items++;
            end else if (p < 6) begin
                send_item(OP_UNUSED, 8'($urandom), 9'($urandom), 16'($urandom),
                          5'($urandom));
            end else begin
                // a new group never extends the previous run
                b = pick_byte();
                while (b == prev_b && b != ESC_BYTE) b = pick_byte();
                p = $urandom_range(99);
                if (!long_run_done && counted_items >= 100) begin
                    run_n = $urandom_range(255, 260);  // reaches or crosses the run limit
                    if (b == ESC_BYTE) b = 8'h77;
                    long_run_done = 1'b1;
                end else if (p < 55) run_n = 1;
                else if (p < 75) run_n = 2;
                else if (p < 93) run_n = $urandom_range(3, 8);
                else run_n = $urandom_range(9, 40);
                repeat (run_n) send_byte(b);
                prev_b = b;
                counted_items += run_n;
                if ($urandom_range(99) < 10) begin
                    send_end();
                    counted_items++;
                end
            end
        end
        send_end();

        // Wait for the last bytes, then give the block time for strays
        set_idling(0);
        push <= 1'b0;
        while (sb.owed_bytes.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5ms;
        $display("Regression FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/rhse_pkg.sv
rtl/rhse_front.sv
rtl/rhse_back.sv
rtl/rhse_outq.sv
rtl/rle_huffman_stream_encoder_unit.sv
sim/tb.sv
